// ----- design/bcaf_pkg.sv -----
// Shared constants, result codes and types of the bound chain absorption filter.
package bcaf_pkg;

	localparam int POOL_DEPTH = 256;
	localparam int AW = $clog2(POOL_DEPTH);
	localparam int CW = AW + 1;
	localparam int BW = 8;
	localparam int VW = 2;

	localparam logic [VW-1:0] VERDICT_ACCEPTED = 2'd0;
	localparam logic [VW-1:0] VERDICT_ABSORBED = 2'd1;
	localparam logic [VW-1:0] VERDICT_OVERFLOW = 2'd2;

	typedef struct packed {
		logic done;
		logic absorbed;
	} walk_status_t;

endpackage

// ----- design/bcaf_pool_ram.sv -----
// Chain pool memory with one write port and two registered read ports.
module bcaf_pool_ram (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [bcaf_pkg::AW-1:0]  wr_addr,
	input  logic [bcaf_pkg::BW-1:0]  wr_data,
	input  logic [bcaf_pkg::AW-1:0]  rd_addr_a,
	input  logic [bcaf_pkg::AW-1:0]  rd_addr_b,
	output logic [bcaf_pkg::BW-1:0]  rd_data_a,
	output logic [bcaf_pkg::BW-1:0]  rd_data_b
);
	import bcaf_pkg::*;

	logic [BW-1:0] mem [POOL_DEPTH];
	logic [BW-1:0] rd_a_q;
	logic [BW-1:0] rd_b_q;
	logic          zero_a_q;
	logic          zero_b_q;

	// Entry zero is the leading separator and is never written; its reads are forced to zero.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_q   <= mem[rd_addr_a];
		rd_b_q   <= mem[rd_addr_b];
		zero_a_q <= (rd_addr_a == '0);
		zero_b_q <= (rd_addr_b == '0);
	end

	assign rd_data_a = zero_a_q ? '0 : rd_a_q;
	assign rd_data_b = zero_b_q ? '0 : rd_b_q;

endmodule

// ----- design/bcaf_walk.sv -----
// Merge walk engine that compares the new chain with each stored chain in turn.
module bcaf_walk (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bcaf_pkg::AW-1:0]      base,
	input  logic [bcaf_pkg::AW-1:0]      b_end,
	input  logic [bcaf_pkg::BW-1:0]      rd_a,
	input  logic [bcaf_pkg::BW-1:0]      rd_b,
	output logic [bcaf_pkg::AW-1:0]      addr_a,
	output logic [bcaf_pkg::AW-1:0]      addr_b,
	output bcaf_pkg::walk_status_t       status
);
	import bcaf_pkg::*;

	localparam logic [1:0] DRV_NONE = 2'd0;
	localparam logic [1:0] DRV_A    = 2'd1;
	localparam logic [1:0] DRV_B    = 2'd2;

	logic          active_q, active_d;
	logic [AW-1:0] a_q, a_d;
	logic [AW-1:0] b_q, b_d;
	logic [AW-1:0] start_q, start_d;
	logic          matched_q, matched_d;
	logic          identical_q, identical_d;
	logic [1:0]    driver_q, driver_d;
	logic [1:0]    drv;
	logic          a_at_end;
	logic          b_at_end;

	always_comb begin
		active_d    = active_q;
		a_d         = a_q;
		b_d         = b_q;
		start_d     = start_q;
		matched_d   = matched_q;
		identical_d = identical_q;
		driver_d    = driver_q;
		status      = '0;
		a_at_end    = (a_q != start_q) && (rd_a == '0);
		b_at_end    = (b_q == b_end);
		drv         = driver_q;
		if (driver_q == DRV_NONE) begin
			drv = (rd_a < rd_b) ? DRV_A : DRV_B;
		end
		priority if (start) begin
			active_d    = 1'b1;
			a_d         = '0;
			start_d     = '0;
			b_d         = base;
			matched_d   = 1'b0;
			identical_d = 1'b1;
			driver_d    = DRV_NONE;
		end else if (active_q) begin
			priority if (a_at_end) begin
				if (matched_q && !identical_q) begin
					status.done     = 1'b1;
					status.absorbed = 1'b1;
					active_d        = 1'b0;
				end else if (a_q == base) begin
					status.done = 1'b1;
					active_d    = 1'b0;
				end else begin
					start_d     = a_q;
					b_d         = base;
					matched_d   = 1'b0;
					identical_d = 1'b1;
					driver_d    = DRV_NONE;
				end
			end else if (a_q == base) begin
				status.done = 1'b1;
				active_d    = 1'b0;
			end else if (b_at_end) begin
				a_d = a_q + AW'(1);
			end else if (rd_a == rd_b) begin
				a_d       = a_q + AW'(1);
				b_d       = b_q + AW'(1);
				driver_d  = DRV_NONE;
				matched_d = 1'b1;
			end else begin
				if (drv == DRV_A) begin
					a_d = a_q + AW'(1);
				end else begin
					b_d = b_q + AW'(1);
				end
				driver_d    = drv;
				matched_d   = 1'b0;
				identical_d = 1'b0;
			end
		end else begin
			active_d = 1'b0;
		end
	end

	assign addr_a = a_d;
	assign addr_b = b_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else begin
			active_q <= active_d;
		end
	end

	always_ff @(posedge clk) begin
		a_q         <= a_d;
		b_q         <= b_d;
		start_q     <= start_d;
		matched_q   <= matched_d;
		identical_q <= identical_d;
		driver_q    <= driver_d;
	end

endmodule

// ----- design/bound_chain_absorption_filter_unit.sv -----
// Top level of the bound chain absorption filter: collection, control and result register.
//
// Each bound that does not close a variant is taken while the control is idle and written
// straight into the chain pool. The closing bound goes through the terminator write and
// the merge walk; the pool memory gives one entry per side per cycle, and a walk over a
// pool of P used entries holding C stored chains, for a new chain of n bounds, takes at
// most P + C * (n + 1) steps. An overflowing variant skips the terminator and the walk.
// The pool needs no clearing after reset, and a finished verdict waits in its own
// register, so bounds of the next variant are taken while it is still stalled.
module bound_chain_absorption_filter_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         bound_valid,
	output logic                         bound_stall,
	input  logic [bcaf_pkg::BW-1:0]      bound_position,
	input  logic                         chain_last,
	output logic                         verdict_valid,
	input  logic                         verdict_stall,
	output logic [bcaf_pkg::VW-1:0]      verdict
);
	import bcaf_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_TERM = 2'd1;
	localparam logic [1:0] ST_WALK = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam logic [CW:0] DEPTH_W = (CW+1)'(POOL_DEPTH);

	logic [1:0]    state_q;
	logic [CW-1:0] pool_used_q;
	logic [CW-1:0] pending_q;
	logic [CW-1:0] n_q;
	logic [VW-1:0] result_q;
	logic          verdict_valid_q;
	logic [VW-1:0] verdict_q;

	logic          accept;
	logic [CW-1:0] pending_next;
	logic [CW:0]   slot;
	logic [CW:0]   room_sum;
	logic          overflow;
	logic [AW-1:0] base;
	logic [AW-1:0] b_end;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [BW-1:0] wr_data;
	logic [AW-1:0] rd_addr_a;
	logic [AW-1:0] rd_addr_b;
	logic [BW-1:0] rd_data_a;
	logic [BW-1:0] rd_data_b;
	logic          out_free;
	walk_status_t  walk_status;

	assign bound_stall   = (state_q != ST_IDLE);
	assign accept        = bound_valid && !bound_stall;
	assign pending_next  = ({1'b0, pending_q} < DEPTH_W) ? pending_q + CW'(1) : pending_q;
	assign slot          = {1'b0, pool_used_q} + {1'b0, pending_q};
	assign room_sum      = {1'b0, pool_used_q} + {1'b0, pending_next} + (CW+1)'(1);
	assign overflow      = (room_sum >= DEPTH_W);
	assign base          = pool_used_q[AW-1:0] - AW'(1);
	assign b_end         = pool_used_q[AW-1:0] + n_q[AW-1:0];
	assign out_free      = !verdict_valid_q || !verdict_stall;

	always_comb begin
		if (state_q == ST_TERM) begin
			wr_en   = 1'b1;
			wr_addr = b_end;
			wr_data = '0;
		end else begin
			wr_en   = accept && (slot < DEPTH_W);
			wr_addr = slot[AW-1:0];
			wr_data = bound_position;
		end
	end

	bcaf_pool_ram u_pool (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	bcaf_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_TERM),
		.base   (base),
		.b_end  (b_end),
		.rd_a   (rd_data_a),
		.rd_b   (rd_data_b),
		.addr_a (rd_addr_a),
		.addr_b (rd_addr_b),
		.status (walk_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			pool_used_q     <= CW'(1);
			pending_q       <= '0;
			verdict_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				verdict_valid_q <= 1'b1;
			end else if (!verdict_stall) begin
				verdict_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (chain_last) begin
							pending_q <= '0;
							state_q   <= overflow ? ST_DONE : ST_TERM;
						end else begin
							pending_q <= pending_next;
						end
					end
				end
				ST_TERM: begin
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (walk_status.done) begin
						if (!walk_status.absorbed) begin
							pool_used_q <= pool_used_q + n_q + CW'(1);
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && chain_last) begin
			n_q      <= pending_next;
			result_q <= VERDICT_OVERFLOW;
		end
		if (state_q == ST_WALK && walk_status.done) begin
			result_q <= walk_status.absorbed ? VERDICT_ABSORBED : VERDICT_ACCEPTED;
		end
		if (state_q == ST_DONE && out_free) begin
			verdict_q <= result_q;
		end
	end

	assign verdict_valid = verdict_valid_q;
	assign verdict       = verdict_q;

endmodule
